// ===== rtl/stereo_modulated_feedback_delay_unit_defines.svh =====
// Assertion macros for the checker file of the delay unit.
`ifndef STEREO_MODULATED_FEEDBACK_DELAY_UNIT_DEFINES_SVH
`define STEREO_MODULATED_FEEDBACK_DELAY_UNIT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define SMFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smfd_pkg.sv =====
`timescale 1ns / 1ps

package smfd_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_QUARTER = SINE_ENTRIES / 4;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
    localparam int QTR_W        = SINE_IDX_W - 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_ANALOG,
        MODE_TAPE,
        MODE_PINGPONG
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_MIX,
        REG_DELAY_TIME,
        REG_FEEDBACK_GAIN,
        REG_WOW_STEP,
        REG_FLUTTER_STEP,
        REG_WOW_DEPTH,
        REG_FLUTTER_DEPTH
    } reg_idx_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] mix;
        logic [23:0] delay_time;
        logic [14:0] feedback_gain;
        logic [31:0] wow_step;
        logic [31:0] flutter_step;
        logic [19:0] wow_depth;
        logic [19:0] flutter_depth;
    } cfg_t;

    // datapath commands issued by the controller, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SINE,
        OP_MOD,
        OP_DELAY,
        OP_PTR,
        OP_RD_LO,
        OP_RD_HI,
        OP_INTERP,
        OP_FEEDBACK,
        OP_SMOOTH,
        OP_WRITE,
        OP_MIX,
        OP_PASS,
        OP_LOAD
    } op_t;

    localparam logic signed [47:0] SAT_HI = 48'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;

    function automatic sample_t sat48(logic signed [47:0] x);
        logic signed [47:0] y;
        y = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
        return y[SAMPLE_BITS-1:0];
    endfunction

    typedef logic [15:0] sine_tab_t [0:SINE_QUARTER];

    // quintic quarter-wave, evaluated at elaboration
    function automatic logic [15:0] sine_point(longint j);
        longint t, t2, inner, mid, s;
        t = (j * 65536) / SINE_QUARTER;
        t2 = (t * t) >> 16;
        inner = 42334 - ((t2 * 5210) >> 16);
        mid = 102944 - ((t2 * inner) >> 16);
        s = ((t * mid) >> 16) >> 1;
        if (s > 32767) begin
            s = 32767;
        end
        return s[15:0];
    endfunction

    function automatic sine_tab_t sine_table();
        sine_tab_t tab;
        for (int i = 0; i <= SINE_QUARTER; i++) begin
            tab[i] = sine_point(longint'(i));
        end
        return tab;
    endfunction

endpackage

// ===== rtl/smfd_regs.sv =====
`timescale 1ns / 1ps

module smfd_regs
    import smfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= MODE_OFF;
            cfg_reg.mix           <= 16'd16384;
            cfg_reg.delay_time    <= 24'd2560000;
            cfg_reg.feedback_gain <= 15'd16384;
            cfg_reg.wow_step      <= 32'd26844;
            cfg_reg.flutter_step  <= 32'd715828;
            cfg_reg.wow_depth     <= 20'd147456;
            cfg_reg.flutter_depth <= 20'd24576;
        end else if (wr_en) begin
            case (idx)
                REG_MODE:          cfg_reg.mode          <= mode_t'(pwdata[1:0]);
                REG_MIX:           cfg_reg.mix           <= pwdata[15:0];
                REG_DELAY_TIME:    cfg_reg.delay_time    <= pwdata[23:0];
                REG_FEEDBACK_GAIN: cfg_reg.feedback_gain <= pwdata[14:0];
                REG_WOW_STEP:      cfg_reg.wow_step      <= pwdata;
                REG_FLUTTER_STEP:  cfg_reg.flutter_step  <= pwdata;
                REG_WOW_DEPTH:     cfg_reg.wow_depth     <= pwdata[19:0];
                REG_FLUTTER_DEPTH: cfg_reg.flutter_depth <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MODE:          prdata = {30'd0, cfg_reg.mode};
            REG_MIX:           prdata = {16'd0, cfg_reg.mix};
            REG_DELAY_TIME:    prdata = {8'd0, cfg_reg.delay_time};
            REG_FEEDBACK_GAIN: prdata = {17'd0, cfg_reg.feedback_gain};
            REG_WOW_STEP:      prdata = cfg_reg.wow_step;
            REG_FLUTTER_STEP:  prdata = cfg_reg.flutter_step;
            REG_WOW_DEPTH:     prdata = {12'd0, cfg_reg.wow_depth};
            REG_FLUTTER_DEPTH: prdata = {12'd0, cfg_reg.flutter_depth};
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== rtl/smfd_ctrl.sv =====
`timescale 1ns / 1ps

module smfd_ctrl
    import smfd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  logic mode_off,
    output op_t  op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS,
        ST_SINE,
        ST_MOD,
        ST_DELAY,
        ST_PTR,
        ST_RD_LO,
        ST_RD_HI,
        ST_INTERP,
        ST_FEEDBACK,
        ST_SMOOTH,
        ST_WRITE,
        ST_MIX,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   can_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign can_load = !m_valid_reg || m_ready;

    always_comb begin
        case (state_reg)
            ST_IDLE:     op = s_valid ? OP_CAPTURE : OP_NONE;
            ST_PASS:     op = OP_PASS;
            ST_SINE:     op = OP_SINE;
            ST_MOD:      op = OP_MOD;
            ST_DELAY:    op = OP_DELAY;
            ST_PTR:      op = OP_PTR;
            ST_RD_LO:    op = OP_RD_LO;
            ST_RD_HI:    op = OP_RD_HI;
            ST_INTERP:   op = OP_INTERP;
            ST_FEEDBACK: op = OP_FEEDBACK;
            ST_SMOOTH:   op = OP_SMOOTH;
            ST_WRITE:    op = OP_WRITE;
            ST_MIX:      op = OP_MIX;
            ST_OUT:      op = can_load ? OP_LOAD : OP_NONE;
            default:     op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= mode_off ? ST_PASS : ST_SINE;
                    end
                end
                ST_PASS:     state_reg <= ST_OUT;
                ST_SINE:     state_reg <= ST_MOD;
                ST_MOD:      state_reg <= ST_DELAY;
                ST_DELAY:    state_reg <= ST_PTR;
                ST_PTR:      state_reg <= ST_RD_LO;
                ST_RD_LO:    state_reg <= ST_RD_HI;
                ST_RD_HI:    state_reg <= ST_INTERP;
                ST_INTERP:   state_reg <= ST_FEEDBACK;
                ST_FEEDBACK: state_reg <= ST_SMOOTH;
                ST_SMOOTH:   state_reg <= ST_WRITE;
                ST_WRITE:    state_reg <= ST_MIX;
                ST_MIX:      state_reg <= ST_OUT;
                ST_OUT: begin
                    if (can_load) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/smfd_dp.sv =====
`timescale 1ns / 1ps

module smfd_dp
    import smfd_pkg::*;
#(
    parameter int LINE_DEPTH = 65536
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  op_t     op,
    input  sample_t left_in,
    input  sample_t right_in,
    output sample_t left_out,
    output sample_t right_out,
    output logic    mode_off
);

    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int DLY_W = AW + 8;
    localparam int CMP_W = ((DLY_W > 24) ? DLY_W : 24) + 1;
    localparam int SUM_W = CMP_W + 2;
    localparam int DELAY_HI = (LINE_DEPTH - 2) * 256;
    localparam logic [DLY_W:0]            LINE_SPAN = (DLY_W + 1)'(LINE_DEPTH * 256);
    localparam logic [CMP_W-1:0]          CMP_LO    = CMP_W'(256);
    localparam logic [CMP_W-1:0]          CMP_HI    = CMP_W'(DELAY_HI);
    localparam logic signed [SUM_W-1:0]   SUM_LO    = SUM_W'(256);
    localparam logic signed [SUM_W-1:0]   SUM_HI    = SUM_W'(DELAY_HI);
    localparam logic [AW-1:0]             LAST_IDX  = AW'(LINE_DEPTH - 1);
    localparam sine_tab_t SINE_TAB = sine_table();

    sample_t left_mem  [0:LINE_DEPTH-1];
    sample_t right_mem [0:LINE_DEPTH-1];

    // control state
    logic [AW-1:0] wi_reg;
    logic          wrapped_reg;
    logic [31:0]   wow_phase_reg, flutter_phase_reg;
    sample_t       smooth_l_reg, smooth_r_reg, last_l_reg, last_r_reg;

    // working registers
    sample_t              dry_l_reg, dry_r_reg;
    logic [16:0]          sin_w_reg, sin_f_reg;
    logic [DLY_W-1:0]     base_reg, delay_reg;
    logic signed [21:0]   w_reg, fl_reg;
    logic [AW-1:0]        i0_reg, i1_reg;
    logic [7:0]           frac_reg;
    logic                 rd_ok_reg;
    sample_t              rd_l_reg, rd_r_reg, a_l_reg, a_r_reg;
    sample_t              wet_l_reg, wet_r_reg, fb_l_reg, fb_r_reg;
    sample_t              mix_l_reg, mix_r_reg, out_l_reg, out_r_reg;

    logic [CMP_W-1:0]       dt_ext;
    logic [DLY_W-1:0]       base_next;
    logic [35:0]            prod_w, prod_f;
    logic signed [21:0]     w_pos, fl_pos;
    logic signed [SUM_W-1:0] dsum;
    logic [DLY_W-1:0]       delay_next;
    logic [DLY_W:0]         diff, ptr;
    logic [AW-1:0]          i0_next, rd_addr;
    logic                   rd_en, wr_en;
    sample_t                b_l, b_r, src_l, src_r, wval_l, wval_r;
    logic                   analog, tape, pingpong;

    // returns {negative, magnitude}
    function automatic logic [16:0] sine_lookup(logic [31:0] ph);
        logic [SINE_IDX_W-1:0] k;
        logic [QTR_W:0]        idx;
        k   = ph[31 -: SINE_IDX_W];
        idx = k[SINE_IDX_W-2] ? ((QTR_W + 1)'(SINE_QUARTER) - {1'b0, k[QTR_W-1:0]})
                              : {1'b0, k[QTR_W-1:0]};
        return {k[SINE_IDX_W-1], SINE_TAB[idx]};
    endfunction

    function automatic sample_t interp(sample_t a, sample_t b, logic [7:0] f);
        logic signed [34:0] pa, pb, s;
        pa = 35'(a) * $signed({26'd0, 9'(9'd256 - {1'b0, f})});
        pb = 35'(b) * $signed({27'd0, f});
        s  = pa + pb;
        return s[31:8];
    endfunction

    function automatic sample_t scale_fb(sample_t x, logic [14:0] g);
        logic signed [39:0] p;
        p = 40'(x) * $signed({25'd0, g});
        return p[38:15];
    endfunction

    function automatic sample_t lowpass(sample_t x, sample_t s, logic quarter);
        logic signed [26:0] acc;
        if (quarter) begin
            acc = 27'(x) + 27'(x) + 27'(x) + 27'(s);
            return sat48(48'(acc >>> 2));
        end else begin
            acc = 27'(x) + 27'(s);
            return sat48(48'(acc >>> 1));
        end
    endfunction

    function automatic sample_t mix_out(sample_t dry, sample_t wet, logic [15:0] mix);
        logic [15:0]        m, inv;
        logic signed [41:0] acc;
        m   = (mix > 16'd32768) ? 16'd32768 : mix;
        inv = 16'd32768 - m;
        acc = 42'(dry) * $signed({26'd0, inv}) + 42'(wet) * $signed({26'd0, m});
        return sat48(48'(acc >>> 15));
    endfunction

    assign mode_off  = (cfg.mode == MODE_OFF);
    assign analog    = (cfg.mode == MODE_ANALOG);
    assign tape      = (cfg.mode == MODE_TAPE);
    assign pingpong  = (cfg.mode == MODE_PINGPONG);
    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

    always_comb begin
        dt_ext = CMP_W'(cfg.delay_time);
        if (dt_ext < CMP_LO) begin
            base_next = DLY_W'(256);
        end else if (dt_ext > CMP_HI) begin
            base_next = DLY_W'(DELAY_HI);
        end else begin
            base_next = dt_ext[DLY_W-1:0];
        end
    end

    // modulation offsets truncate toward zero: scale the magnitude, then sign
    assign prod_w = 36'(cfg.wow_depth) * 36'(sin_w_reg[15:0]);
    assign prod_f = 36'(cfg.flutter_depth) * 36'(sin_f_reg[15:0]);
    assign w_pos  = $signed({1'b0, prod_w[35:15]});
    assign fl_pos = $signed({1'b0, prod_f[35:15]});

    assign dsum = $signed({(SUM_W - DLY_W)'(0), base_reg}) + SUM_W'(w_reg) + SUM_W'(fl_reg);

    always_comb begin
        if (!tape) begin
            delay_next = base_reg;
        end else if (dsum < SUM_LO) begin
            delay_next = DLY_W'(256);
        end else if (dsum > SUM_HI) begin
            delay_next = DLY_W'(DELAY_HI);
        end else begin
            delay_next = dsum[DLY_W-1:0];
        end
    end

    assign diff    = {1'b0, wi_reg, 8'd0} - {1'b0, delay_reg};
    assign ptr     = diff[DLY_W] ? (diff + LINE_SPAN) : diff;
    assign i0_next = ptr[DLY_W-1:8];

    assign rd_en   = (op == OP_RD_LO) || (op == OP_RD_HI);
    assign rd_addr = (op == OP_RD_HI) ? i1_reg : i0_reg;
    assign wr_en   = (op == OP_WRITE);

    // entries not yet written since reset read as zero
    assign b_l = rd_ok_reg ? rd_l_reg : '0;
    assign b_r = rd_ok_reg ? rd_r_reg : '0;

    assign src_l  = pingpong ? last_r_reg : wet_l_reg;
    assign src_r  = pingpong ? last_l_reg : wet_r_reg;
    assign wval_l = sat48(48'(dry_l_reg) + 48'(smooth_l_reg));
    assign wval_r = sat48(48'(dry_r_reg) + 48'(smooth_r_reg));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            left_mem[wi_reg]  <= wval_l;
            right_mem[wi_reg] <= wval_r;
        end
        if (rd_en) begin
            rd_l_reg <= left_mem[rd_addr];
            rd_r_reg <= right_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg            <= '0;
            wrapped_reg       <= 1'b0;
            wow_phase_reg     <= '0;
            flutter_phase_reg <= '0;
            smooth_l_reg      <= '0;
            smooth_r_reg      <= '0;
            last_l_reg        <= '0;
            last_r_reg        <= '0;
        end else begin
            case (op)
                OP_MOD: begin
                    if (tape) begin
                        wow_phase_reg     <= wow_phase_reg + cfg.wow_step;
                        flutter_phase_reg <= flutter_phase_reg + cfg.flutter_step;
                    end
                end
                OP_SMOOTH: begin
                    smooth_l_reg <= lowpass(fb_l_reg, smooth_l_reg, analog);
                    smooth_r_reg <= lowpass(fb_r_reg, smooth_r_reg, analog);
                end
                OP_WRITE: begin
                    wi_reg <= (wi_reg == LAST_IDX) ? '0 : wi_reg + 1'b1;
                    if (wi_reg == LAST_IDX) begin
                        wrapped_reg <= 1'b1;
                    end
                    if (pingpong) begin
                        last_l_reg <= wet_l_reg;
                        last_r_reg <= wet_r_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_ok_reg <= wrapped_reg || (rd_addr < wi_reg);
        end
        case (op)
            OP_CAPTURE: begin
                dry_l_reg <= left_in;
                dry_r_reg <= right_in;
            end
            OP_SINE: begin
                sin_w_reg <= sine_lookup(wow_phase_reg);
                sin_f_reg <= sine_lookup(flutter_phase_reg);
                base_reg  <= base_next;
            end
            OP_MOD: begin
                w_reg  <= sin_w_reg[16] ? -w_pos : w_pos;
                fl_reg <= sin_f_reg[16] ? -fl_pos : fl_pos;
            end
            OP_DELAY: delay_reg <= delay_next;
            OP_PTR: begin
                i0_reg   <= i0_next;
                i1_reg   <= (i0_next == LAST_IDX) ? '0 : i0_next + 1'b1;
                frac_reg <= ptr[7:0];
            end
            OP_RD_HI: begin
                a_l_reg <= b_l;
                a_r_reg <= b_r;
            end
            OP_INTERP: begin
                wet_l_reg <= interp(a_l_reg, b_l, frac_reg);
                wet_r_reg <= interp(a_r_reg, b_r, frac_reg);
            end
            OP_FEEDBACK: begin
                fb_l_reg <= scale_fb(src_l, cfg.feedback_gain);
                fb_r_reg <= scale_fb(src_r, cfg.feedback_gain);
            end
            OP_MIX: begin
                mix_l_reg <= mix_out(dry_l_reg, wet_l_reg, cfg.mix);
                mix_r_reg <= mix_out(dry_r_reg, wet_r_reg, cfg.mix);
            end
            OP_PASS: begin
                mix_l_reg <= dry_l_reg;
                mix_r_reg <= dry_r_reg;
            end
            OP_LOAD: begin
                out_l_reg <= mix_l_reg;
                out_r_reg <= mix_r_reg;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/stereo_modulated_feedback_delay_unit.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                   Carries
// s_        s_valid s_ready s_left_in s_right_in    dry stereo word, Q1.23
// m_        m_valid m_ready m_left_out m_right_out  mixed stereo word, Q1.23
// APB       psel penable pwrite paddr pwdata ...    registers at 4*index
//
// Off mode: accept, pass, output load. A new word is taken only once the last is loaded.
// Other modes: a longer sequence of steps, set by the single port of each delay line
// (two interpolation reads and one write) and the registered multiply steps.
// A finished word waits in the output register; loading stalls while it is held.
// Reset is synchronous; the lines need no clearing, a fill count masks unwritten entries.

module stereo_modulated_feedback_delay_unit
    import smfd_pkg::*;
#(
    parameter int LINE_DEPTH = 65536
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sample_t     s_left_in,
    input  sample_t     s_right_in,
    output logic        m_valid,
    input  logic        m_ready,
    output sample_t     m_left_out,
    output sample_t     m_right_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    op_t  op;
    logic mode_off;

    smfd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .mode_off (mode_off),
        .op       (op)
    );

    smfd_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .op        (op),
        .left_in   (s_left_in),
        .right_in  (s_right_in),
        .left_out  (m_left_out),
        .right_out (m_right_out),
        .mode_off  (mode_off)
    );

endmodule

// ===== rtl/smfd_checker.sv =====
`timescale 1ns / 1ps
`include "stereo_modulated_feedback_delay_unit_defines.svh"

module smfd_checker
    import smfd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input sample_t     m_left_out,
    input sample_t     m_right_out,
    input logic        psel,
    input logic        pready
);

    // one word in flight: input closes right after an accept
    `SMFD_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "word accepted while busy")

    `SMFD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_left_out) && $stable(m_right_out), "stalled result changed")

    `SMFD_ASSERT_NOW(a_pready, psel, pready, "register port stalled")

    `SMFD_ASSERT_NOW(a_reset_empty, $past(!aresetn), !m_valid, "result valid out of reset")

endmodule

bind stereo_modulated_feedback_delay_unit smfd_checker u_smfd_checker (.*);
